// ----- rtl/kpc_pkg.sv -----
`default_nettype none
package kpc_pkg;

  localparam int TICK_W     = 10;
  localparam int CONF_W     = 8;
  localparam int EV_W       = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [TICK_W-1:0] TICK_MAX = 10'd1023;
  localparam logic [CONF_W-1:0] CONF_MAX = 8'd255;

  // press_event codes
  localparam logic [EV_W-1:0] EV_NONE   = 2'd0;
  localparam logic [EV_W-1:0] EV_SINGLE = 2'd1;
  localparam logic [EV_W-1:0] EV_DOUBLE = 2'd2;
  localparam logic [EV_W-1:0] EV_LONG   = 2'd3;

  typedef struct packed {
    logic [CONF_W-1:0] debounce_ticks;
    logic [TICK_W-1:0] long_press_ticks;
    logic [TICK_W-1:0] double_window_ticks;
    logic [CONF_W-1:0] confirm_ticks;
  } cfg_t;

endpackage
`default_nettype wire

// ----- rtl/kpc_cfg_regs.sv -----
`default_nettype none
module kpc_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  input  wire logic [kpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [kpc_pkg::CFG_DATA_W-1:0] cfg_data,
  output kpc_pkg::cfg_t                       cfg
);
  import kpc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CONFIRM  = 2'd3;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks      <= 8'd2;
      cfg_r.long_press_ticks    <= 10'd500;
      cfg_r.double_window_ticks <= 10'd100;
      cfg_r.confirm_ticks       <= 8'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEBOUNCE: cfg_r.debounce_ticks      <= cfg_data[CONF_W-1:0];
        REG_LONG:     cfg_r.long_press_ticks    <= cfg_data[TICK_W-1:0];
        REG_WINDOW:   cfg_r.double_window_ticks <= cfg_data[TICK_W-1:0];
        REG_CONFIRM:  cfg_r.confirm_ticks       <= cfg_data[CONF_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ----- rtl/kpc_classify.sv -----
`default_nettype none
module kpc_classify (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      advance,
  input  wire logic                      key_down,
  input  kpc_pkg::cfg_t                  cfg,
  output logic [kpc_pkg::EV_W-1:0]       ev
);
  import kpc_pkg::*;

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_DEBOUNCE = 3'd1;
  localparam logic [2:0] PH_HOLD     = 3'd2;
  localparam logic [2:0] PH_WINDOW   = 3'd3;
  localparam logic [2:0] PH_CONFIRM  = 3'd4;
  localparam logic [2:0] PH_WAITREL  = 3'd5;

  logic [2:0]        phase_r, phase_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic [CONF_W-1:0] conf_r, conf_nxt;

  always_comb begin
    logic [TICK_W-1:0] tick_inc;
    logic [CONF_W-1:0] conf_inc;
    tick_inc  = (tick_r == TICK_MAX) ? TICK_MAX : tick_r + 10'd1;
    conf_inc  = (conf_r == CONF_MAX) ? CONF_MAX : conf_r + 8'd1;
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    conf_nxt  = conf_r;
    ev        = EV_NONE;
    unique case (phase_r)
      PH_DEBOUNCE: begin
        tick_nxt = tick_inc;
        if (tick_inc >= {2'b00, cfg.debounce_ticks}) begin
          tick_nxt  = '0;
          phase_nxt = key_down ? PH_HOLD : PH_IDLE;
        end
      end
      PH_HOLD: begin
        if (key_down) begin
          tick_nxt = tick_inc;
          if (tick_inc >= cfg.long_press_ticks) begin
            ev        = EV_LONG;
            tick_nxt  = '0;
            phase_nxt = PH_IDLE;
          end
        end else begin
          tick_nxt  = '0;
          phase_nxt = PH_WINDOW;
        end
      end
      PH_WINDOW: begin
        tick_nxt = tick_inc;
        if (key_down) begin
          conf_nxt  = '0;
          phase_nxt = PH_CONFIRM;
        end else if (tick_inc >= cfg.double_window_ticks) begin
          ev        = EV_SINGLE;
          tick_nxt  = '0;
          phase_nxt = PH_IDLE;
        end
      end
      PH_CONFIRM: begin
        // window count keeps running while the second press is confirmed
        tick_nxt = tick_inc;
        conf_nxt = conf_inc;
        if (conf_inc >= cfg.confirm_ticks) begin
          conf_nxt = '0;
          if (key_down) begin
            phase_nxt = PH_WAITREL;
          end else if (tick_inc >= cfg.double_window_ticks) begin
            ev        = EV_SINGLE;
            tick_nxt  = '0;
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = PH_WINDOW;
          end
        end
      end
      PH_WAITREL: begin
        if (!key_down) begin
          ev        = EV_DOUBLE;
          tick_nxt  = '0;
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        // idle and the unused codes
        tick_nxt  = '0;
        conf_nxt  = '0;
        phase_nxt = key_down ? PH_DEBOUNCE : PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tick_r  <= '0;
      conf_r  <= '0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      conf_r  <= conf_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/kpc_out_buf.sv -----
`default_nettype none
module kpc_out_buf (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      push,
  input  wire logic [kpc_pkg::EV_W-1:0]  push_ev,
  output logic                           can_push,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [kpc_pkg::EV_W-1:0]       out_ev,
  output logic                           skid_valid
);
  import kpc_pkg::*;

  logic            out_valid_r;
  logic [EV_W-1:0] out_ev_r;
  logic            skid_valid_r;
  logic [EV_W-1:0] skid_ev_r;
  logic            pop;

  assign pop = out_valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_ev_r     <= skid_ev_r;
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || pop) begin
      out_valid_r <= push;
      if (push) begin
        out_ev_r <= push_ev;
      end
    end else if (push) begin
      // result register still held: park the word in the skid stage
      skid_ev_r    <= push_ev;
      skid_valid_r <= 1'b1;
    end
  end

  assign can_push   = !skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_ev     = out_ev_r;
  assign skid_valid = skid_valid_r;

endmodule
`default_nettype wire

// ----- rtl/key_press_classifier.sv -----
`default_nettype none
// key_press_classifier: single, double and long press detection on a button line
// throughput: one word per cycle, sustained while out_ready stays high
// a result word is registered in the result register, or in the skid stage while that is held
// a two-entry output stage (result register plus skid) keeps in_ready up while one result waits
// reset (rst_n low, synchronous): classifier idle, counters zero, output empty,
// registers back to debounce 2, long press 500, window 100, confirm 1
module key_press_classifier (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_key_down,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [kpc_pkg::EV_W-1:0]            out_press_event,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [kpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [kpc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import kpc_pkg::*;

  cfg_t            cfg;
  logic            push;
  logic            can_push;
  logic            skid_valid;
  logic [EV_W-1:0] ev;

  assign cfg_ready = 1'b1;
  assign in_ready  = can_push;
  assign push      = in_valid && can_push;

  kpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  kpc_classify u_classify (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (push),
    .key_down (in_key_down),
    .cfg      (cfg),
    .ev       (ev)
  );

  kpc_out_buf u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ev    (ev),
    .can_push   (can_push),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_ev     (out_press_event),
    .skid_valid (skid_valid)
  );

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid |-> out_valid)
    else $error("skid stage holds a word while the result register is empty");

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    push && !out_valid |=> out_valid && out_press_event == $past(ev))
    else $error("accepted word did not reach the result register");

  a_double_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    push && ev == EV_DOUBLE |-> !in_key_down)
    else $error("double press reported while key is down");

  a_long_while_held: assert property (@(posedge clk) disable iff (!rst_n)
    push && ev == EV_LONG |-> in_key_down)
    else $error("long press reported while key is up");

endmodule
`default_nettype wire
